/* rtl/core/scmix_pkg.sv */
// ----------------------------------------------------------------------------
// scmix_pkg
// Shared types, register map, field positions and the pan gain table of the
// stereo channel mixer.
// ----------------------------------------------------------------------------
package scmix_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int NCH       = 6;
  localparam int NBUS      = 6;
  localparam int SET_W     = 61;
  localparam int CH_W      = 3;
  localparam int BUS_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam int CHANNEL_COUNT_DEF = 6;
  localparam int AUX_BUS_COUNT_DEF = 5;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_MASTER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF   = 3'd7;

  localparam logic [SET_W-1:0] SET_RESET    = 61'd6579275;
  localparam logic [7:0]       MASTER_RESET = 8'd100;
  localparam logic [15:0]      COEF_RESET   = 16'd8041;

  // settings word layout
  localparam int MUTE_BIT = 24;
  localparam int SOLO_BIT = 25;
  localparam int SEND_LSB = 26;
  localparam int SEND_W   = 7;

  // exact reciprocals: floor(n/100) = (n*M100)>>29 for n < 2^22,
  // floor(n/10000) = (n*M10000)>>44 for n < 2^30
  localparam logic [31:0] M100   = 32'd5368710;
  localparam logic [31:0] M10000 = 32'd1759218605;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Taylor term divisors as rounded-up reciprocals, exact for terms below 2^30:
  // cos uses (2n-1)(2n), sin uses (2n)(2n+1), n = 1..8
  localparam int RCP_SH = 39;
  localparam longint unsigned RCP_COS [8] = '{
    ((64'd1 << RCP_SH) + 64'd1) / 64'd2,
    ((64'd1 << RCP_SH) + 64'd11) / 64'd12,
    ((64'd1 << RCP_SH) + 64'd29) / 64'd30,
    ((64'd1 << RCP_SH) + 64'd55) / 64'd56,
    ((64'd1 << RCP_SH) + 64'd89) / 64'd90,
    ((64'd1 << RCP_SH) + 64'd131) / 64'd132,
    ((64'd1 << RCP_SH) + 64'd181) / 64'd182,
    ((64'd1 << RCP_SH) + 64'd239) / 64'd240
  };
  localparam longint unsigned RCP_SIN [8] = '{
    ((64'd1 << RCP_SH) + 64'd5) / 64'd6,
    ((64'd1 << RCP_SH) + 64'd19) / 64'd20,
    ((64'd1 << RCP_SH) + 64'd41) / 64'd42,
    ((64'd1 << RCP_SH) + 64'd71) / 64'd72,
    ((64'd1 << RCP_SH) + 64'd109) / 64'd110,
    ((64'd1 << RCP_SH) + 64'd155) / 64'd156,
    ((64'd1 << RCP_SH) + 64'd209) / 64'd210,
    ((64'd1 << RCP_SH) + 64'd271) / 64'd272
  };

  typedef logic [14:0] cos_tab_t [201];

  // cos over the first half, sin of the mirrored angle over the second
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned m;
    logic [79:0]     wide;
    longint          sum;
    int              k;
    int              n;
    bit              want_sin;
    for (k = 0; k <= 200; k++) begin
      want_sin = (k > 100);
      x = (want_sin ? longint'(200 - k) : longint'(k)) * PI_Q30 / 400;
      x2 = (x * x) >> 30;
      term = want_sin ? x : (64'd1 << 30);
      sum = longint'(term);
      for (n = 1; n <= 8; n++) begin
        m = want_sin ? RCP_SIN[n-1] : RCP_COS[n-1];
        wide = 80'((term * x2) >> 30) * 80'(m);
        term = 64'(wide >> RCP_SH);
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      t[k] = 15'((sum + 64'sd32768) >>> 16);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  typedef enum logic [4:0] {
    OP_NOP, OP_LM, OP_TLO, OP_GL1, OP_GR1, OP_THI, OP_GL2, OP_GR2,
    OP_FL1, OP_FR1, OP_FL2, OP_FR2, OP_FL3, OP_FR3, OP_ML, OP_MR,
    OP_A1L, OP_A1R, OP_A2L, OP_A2R, OP_A3L, OP_A3R
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic [BUS_W-1:0] bus;
    logic            start;
    logic            fin;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic tilt_flat;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ch0_left;
    logic signed [SAMPLE_W-1:0] ch0_right;
    logic signed [SAMPLE_W-1:0] ch1_left;
    logic signed [SAMPLE_W-1:0] ch1_right;
    logic signed [SAMPLE_W-1:0] ch2_left;
    logic signed [SAMPLE_W-1:0] ch2_right;
    logic signed [SAMPLE_W-1:0] ch3_left;
    logic signed [SAMPLE_W-1:0] ch3_right;
    logic signed [SAMPLE_W-1:0] ch4_left;
    logic signed [SAMPLE_W-1:0] ch4_right;
    logic signed [SAMPLE_W-1:0] ch5_left;
    logic signed [SAMPLE_W-1:0] ch5_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] main_left;
    logic signed [SAMPLE_W-1:0] main_right;
    logic signed [SAMPLE_W-1:0] aux1_left;
    logic signed [SAMPLE_W-1:0] aux1_right;
    logic signed [SAMPLE_W-1:0] aux2_left;
    logic signed [SAMPLE_W-1:0] aux2_right;
    logic signed [SAMPLE_W-1:0] aux3_left;
    logic signed [SAMPLE_W-1:0] aux3_right;
    logic signed [SAMPLE_W-1:0] aux4_left;
    logic signed [SAMPLE_W-1:0] aux4_right;
    logic signed [SAMPLE_W-1:0] aux5_left;
    logic signed [SAMPLE_W-1:0] aux5_right;
  } out_t;

endpackage

/* rtl/core/scmix_ctrl.sv */
// ----------------------------------------------------------------------------
// scmix_ctrl
// Sequencer: walks the channels, issuing one multiplier op a cycle in RUN.
// ----------------------------------------------------------------------------
module scmix_ctrl #(
  parameter int CHANNEL_COUNT = scmix_pkg::CHANNEL_COUNT_DEF,
  parameter int AUX_BUS_COUNT = scmix_pkg::AUX_BUS_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  scmix_pkg::stat_t stat,
  output scmix_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  localparam logic [scmix_pkg::CH_W-1:0]  LAST_CH  = scmix_pkg::CH_W'(CHANNEL_COUNT - 1);
  localparam logic [scmix_pkg::BUS_W-1:0] LAST_BUS = scmix_pkg::BUS_W'(AUX_BUS_COUNT);

  state_t                        state_r, state_nxt;
  scmix_pkg::op_t                op_r, op_nxt;
  logic [scmix_pkg::CH_W-1:0]    ch_r, ch_nxt;
  logic [scmix_pkg::BUS_W-1:0]   bus_r, bus_nxt;
  logic                          chan_done;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ch_nxt    = ch_r;
    bus_nxt   = bus_r;
    chan_done = 1'b0;
    cmd.op    = scmix_pkg::OP_NOP;
    cmd.ch    = ch_r;
    cmd.bus   = bus_r;
    cmd.start = 1'b0;
    cmd.fin   = 1'b0;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          ch_nxt    = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.active) begin
          op_nxt    = scmix_pkg::OP_LM;
          bus_nxt   = '0;
          state_nxt = ST_RUN;
        end else begin
          chan_done = 1'b1;
        end
      end
      ST_RUN: begin
        cmd.op = op_r;
        // L and R chains interleave so each result is ready when read
        unique case (op_r)
          scmix_pkg::OP_LM:  op_nxt = scmix_pkg::OP_TLO;
          scmix_pkg::OP_TLO: op_nxt = scmix_pkg::OP_GL1;
          scmix_pkg::OP_GL1: op_nxt = scmix_pkg::OP_GR1;
          scmix_pkg::OP_GR1: op_nxt = scmix_pkg::OP_THI;
          scmix_pkg::OP_THI: op_nxt = scmix_pkg::OP_GL2;
          scmix_pkg::OP_GL2: op_nxt = scmix_pkg::OP_GR2;
          scmix_pkg::OP_GR2: op_nxt = stat.tilt_flat ? scmix_pkg::OP_ML : scmix_pkg::OP_FL1;
          scmix_pkg::OP_FL1: op_nxt = scmix_pkg::OP_FR1;
          scmix_pkg::OP_FR1: op_nxt = scmix_pkg::OP_FL2;
          scmix_pkg::OP_FL2: op_nxt = scmix_pkg::OP_FR2;
          scmix_pkg::OP_FR2: op_nxt = scmix_pkg::OP_FL3;
          scmix_pkg::OP_FL3: op_nxt = scmix_pkg::OP_FR3;
          scmix_pkg::OP_FR3: op_nxt = scmix_pkg::OP_ML;
          scmix_pkg::OP_ML:  op_nxt = scmix_pkg::OP_MR;
          scmix_pkg::OP_MR: begin
            if (AUX_BUS_COUNT == 0) begin
              chan_done = 1'b1;
            end else begin
              bus_nxt = scmix_pkg::BUS_W'(1);
              op_nxt  = scmix_pkg::OP_A1L;
            end
          end
          scmix_pkg::OP_A1L: op_nxt = scmix_pkg::OP_A1R;
          scmix_pkg::OP_A1R: op_nxt = scmix_pkg::OP_A2L;
          scmix_pkg::OP_A2L: op_nxt = scmix_pkg::OP_A2R;
          scmix_pkg::OP_A2R: op_nxt = scmix_pkg::OP_A3L;
          scmix_pkg::OP_A3L: op_nxt = scmix_pkg::OP_A3R;
          scmix_pkg::OP_A3R: begin
            if (bus_r == LAST_BUS) begin
              chan_done = 1'b1;
            end else begin
              bus_nxt = bus_r + 1'b1;
              op_nxt  = scmix_pkg::OP_A1L;
            end
          end
          default: chan_done = 1'b1;
        endcase
      end
      ST_FLUSH: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (chan_done) begin
      if (ch_r == LAST_CH) begin
        state_nxt = ST_FLUSH;
      end else begin
        ch_nxt    = ch_r + 1'b1;
        state_nxt = ST_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= scmix_pkg::OP_NOP;
      ch_r    <= '0;
      bus_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ch_r    <= ch_nxt;
      bus_r   <= bus_nxt;
    end
  end

endmodule

/* rtl/core/scmix_dp.sv */
// ----------------------------------------------------------------------------
// scmix_dp
// Datapath: settings registers, shared multiplier, tilt filter state, bus
// accumulators and the output register.
// ----------------------------------------------------------------------------
module scmix_dp #(
  parameter int CHANNEL_COUNT = scmix_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scmix_pkg::in_t                    in_data,
  input  logic                              cfg_wr,
  input  logic [scmix_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scmix_pkg::SET_W-1:0]       cfg_data,
  input  scmix_pkg::cmd_t                   cmd,
  output scmix_pkg::stat_t                  stat,
  output scmix_pkg::out_t                   out_data,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int NCH  = scmix_pkg::NCH;
  localparam int NBUS = scmix_pkg::NBUS;

  function automatic logic signed [23:0] pick_x(scmix_pkg::in_t d, logic [2:0] ch, logic rgt);
    logic signed [23:0] v;
    unique case (ch)
      3'd0:    v = rgt ? d.ch0_right : d.ch0_left;
      3'd1:    v = rgt ? d.ch1_right : d.ch1_left;
      3'd2:    v = rgt ? d.ch2_right : d.ch2_left;
      3'd3:    v = rgt ? d.ch3_right : d.ch3_left;
      3'd4:    v = rgt ? d.ch4_right : d.ch4_left;
      3'd5:    v = rgt ? d.ch5_right : d.ch5_left;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] round_sat(logic signed [47:0] acc);
    logic signed [47:0] v;
    logic signed [23:0] r;
    v = (acc + 48'sd8192) >>> 14;
    if (v > 48'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -48'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // configuration
  logic [scmix_pkg::SET_W-1:0] chan_r [NCH];
  logic [7:0]                  master_r;
  logic [15:0]                 coef_r;

  // per-frame working registers, filter state and output
  scmix_pkg::in_t              in_r;
  scmix_pkg::op_t              wb_op_r;
  logic [2:0]                  wb_ch_r;
  logic [2:0]                  wb_bus_r;
  logic signed [63:0]          prod_r;
  logic [14:0]                 lm_r, lo_r, hi_r;
  logic signed [16:0]          diff_r;
  logic [29:0]                 tl_r, tr_r;
  logic [15:0]                 gl_r, gr_r;
  logic signed [32:0]          dl_r, dr_r;
  logic signed [31:0]          nlpl_r, nlpr_r;
  logic signed [49:0]          pl_r, pr_r;
  logic signed [27:0]          yl_r, yr_r;
  logic [21:0]                 sgl_r, sgr_r;
  logic [15:0]                 agl_r, agr_r;
  logic signed [47:0]          acc_r [NBUS][2];
  logic signed [31:0]          lpl_r [NCH];
  logic signed [31:0]          lpr_r [NCH];
  logic                        out_valid_r;
  scmix_pkg::out_t             out_r;

  logic [scmix_pkg::SET_W-1:0] set_c;
  logic [7:0]                  level_c, pan_c, tilt_c, master_c;
  logic [6:0]                  send_raw, send_c;
  logic                        any_solo;
  logic [8:0]                  tlo_a, thi_a;
  logic [14:0]                 cos_l, cos_r;
  logic signed [23:0]          x_cl, x_cr, x_wl, x_wr;
  logic signed [31:0]          xs_cl, xs_cr, xs_wl, xs_wr;
  logic signed [33:0]          a_op;
  logic signed [31:0]          b_op;
  logic signed [65:0]          mult_full;
  logic signed [31:0]          lp_sel, nlp_w;
  logic signed [63:0]          rnd16_w;
  logic signed [49:0]          pl_sel;
  logic signed [63:0]          y_sum, y_w;
  logic                        acc_en, acc_s;
  logic [2:0]                  acc_b;

  // decode current channel
  always_comb begin
    set_c    = chan_r[cmd.ch];
    level_c  = (set_c[7:0] > 8'd150) ? 8'd150 : set_c[7:0];
    pan_c    = (set_c[15:8] > 8'd200) ? 8'd200 : set_c[15:8];
    tilt_c   = (set_c[23:16] > 8'd200) ? 8'd200 : set_c[23:16];
    master_c = (master_r > 8'd150) ? 8'd150 : master_r;
    unique case (cmd.bus)
      3'd1:    send_raw = set_c[scmix_pkg::SEND_LSB +: scmix_pkg::SEND_W];
      3'd2:    send_raw = set_c[scmix_pkg::SEND_LSB + scmix_pkg::SEND_W +: scmix_pkg::SEND_W];
      3'd3:    send_raw = set_c[scmix_pkg::SEND_LSB + 2 * scmix_pkg::SEND_W +: scmix_pkg::SEND_W];
      3'd4:    send_raw = set_c[scmix_pkg::SEND_LSB + 3 * scmix_pkg::SEND_W +: scmix_pkg::SEND_W];
      3'd5:    send_raw = set_c[scmix_pkg::SEND_LSB + 4 * scmix_pkg::SEND_W +: scmix_pkg::SEND_W];
      default: send_raw = '0;
    endcase
    send_c = (send_raw > 7'd100) ? 7'd100 : send_raw;
    any_solo = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      if (c < CHANNEL_COUNT) begin
        any_solo = any_solo | chan_r[c][scmix_pkg::SOLO_BIT];
      end
    end
    tlo_a = 9'd300 - {1'b0, tilt_c};
    thi_a = 9'd100 + {1'b0, tilt_c};
    cos_l = scmix_pkg::COS_TAB[pan_c];
    cos_r = scmix_pkg::COS_TAB[8'd200 - pan_c];
  end

  assign stat.active    = !set_c[scmix_pkg::MUTE_BIT] &&
                          (!any_solo || set_c[scmix_pkg::SOLO_BIT]);
  assign stat.tilt_flat = (tilt_c == 8'd100);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign x_cl  = pick_x(in_r, cmd.ch, 1'b0);
  assign x_cr  = pick_x(in_r, cmd.ch, 1'b1);
  assign x_wl  = pick_x(in_r, wb_ch_r, 1'b0);
  assign x_wr  = pick_x(in_r, wb_ch_r, 1'b1);
  assign xs_cl = {x_cl, 8'h00};
  assign xs_cr = {x_cr, 8'h00};
  assign xs_wl = {x_wl, 8'h00};
  assign xs_wr = {x_wr, 8'h00};

  // operand select for the shared multiplier
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd.op)
      scmix_pkg::OP_LM: begin
        a_op = 34'(level_c);
        b_op = 32'(master_c);
      end
      scmix_pkg::OP_TLO: begin
        a_op = 34'({tlo_a, 13'h0000}) + 34'd50;
        b_op = scmix_pkg::M100;
      end
      scmix_pkg::OP_THI: begin
        a_op = 34'({thi_a, 13'h0000}) + 34'd50;
        b_op = scmix_pkg::M100;
      end
      scmix_pkg::OP_GL1: begin
        a_op = 34'(lm_r);
        b_op = 32'(cos_l);
      end
      scmix_pkg::OP_GR1: begin
        a_op = 34'(lm_r);
        b_op = 32'(cos_r);
      end
      scmix_pkg::OP_GL2: begin
        a_op = 34'(tl_r);
        b_op = scmix_pkg::M10000;
      end
      scmix_pkg::OP_GR2: begin
        a_op = 34'(tr_r);
        b_op = scmix_pkg::M10000;
      end
      scmix_pkg::OP_FL1: begin
        a_op = 34'(dl_r);
        b_op = 32'(coef_r);
      end
      scmix_pkg::OP_FR1: begin
        a_op = 34'(dr_r);
        b_op = 32'(coef_r);
      end
      scmix_pkg::OP_FL2: begin
        a_op = 34'(nlpl_r);
        b_op = 32'(diff_r);
      end
      scmix_pkg::OP_FR2: begin
        a_op = 34'(nlpr_r);
        b_op = 32'(diff_r);
      end
      scmix_pkg::OP_FL3: begin
        a_op = 34'(xs_cl);
        b_op = 32'(hi_r);
      end
      scmix_pkg::OP_FR3: begin
        a_op = 34'(xs_cr);
        b_op = 32'(hi_r);
      end
      scmix_pkg::OP_ML: begin
        a_op = 34'(yl_r);
        b_op = 32'(gl_r);
      end
      scmix_pkg::OP_MR: begin
        a_op = 34'(yr_r);
        b_op = 32'(gr_r);
      end
      scmix_pkg::OP_A1L: begin
        a_op = 34'(gl_r);
        b_op = 32'(send_c);
      end
      scmix_pkg::OP_A1R: begin
        a_op = 34'(gr_r);
        b_op = 32'(send_c);
      end
      scmix_pkg::OP_A2L: begin
        a_op = 34'(sgl_r);
        b_op = scmix_pkg::M100;
      end
      scmix_pkg::OP_A2R: begin
        a_op = 34'(sgr_r);
        b_op = scmix_pkg::M100;
      end
      scmix_pkg::OP_A3L: begin
        a_op = 34'(yl_r);
        b_op = 32'(agl_r);
      end
      scmix_pkg::OP_A3R: begin
        a_op = 34'(yr_r);
        b_op = 32'(agr_r);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign mult_full = a_op * b_op;

  // writeback helpers, all working on the registered product
  always_comb begin
    lp_sel  = (wb_op_r == scmix_pkg::OP_FR1) ? lpr_r[wb_ch_r] : lpl_r[wb_ch_r];
    rnd16_w = (prod_r + 64'sd32768) >>> 16;
    nlp_w   = lp_sel + rnd16_w[31:0];
    pl_sel  = (wb_op_r == scmix_pkg::OP_FR3) ? pr_r : pl_r;
    y_sum   = prod_r + 64'(pl_sel) + 64'sd2097152;
    y_w     = y_sum >>> 22;
    acc_en  = 1'b0;
    acc_b   = '0;
    acc_s   = 1'b0;
    unique case (wb_op_r)
      scmix_pkg::OP_ML: begin
        acc_en = 1'b1;
      end
      scmix_pkg::OP_MR: begin
        acc_en = 1'b1;
        acc_s  = 1'b1;
      end
      scmix_pkg::OP_A3L: begin
        acc_en = 1'b1;
        acc_b  = wb_bus_r;
      end
      scmix_pkg::OP_A3R: begin
        acc_en = 1'b1;
        acc_b  = wb_bus_r;
        acc_s  = 1'b1;
      end
      default: acc_en = 1'b0;
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        chan_r[c] <= scmix_pkg::SET_RESET;
        lpl_r[c]  <= '0;
        lpr_r[c]  <= '0;
      end
      master_r    <= scmix_pkg::MASTER_RESET;
      coef_r      <= scmix_pkg::COEF_RESET;
      wb_op_r     <= scmix_pkg::OP_NOP;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        priority if (cfg_index == scmix_pkg::REG_MASTER) begin
          master_r <= cfg_data[7:0];
        end else if (cfg_index == scmix_pkg::REG_COEF) begin
          coef_r <= cfg_data[15:0];
        end else begin
          chan_r[cfg_index] <= cfg_data;
        end
      end
      wb_op_r <= cmd.op;
      if (wb_op_r == scmix_pkg::OP_FL1) begin
        lpl_r[wb_ch_r] <= nlp_w;
      end
      if (wb_op_r == scmix_pkg::OP_FR1) begin
        lpr_r[wb_ch_r] <= nlp_w;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    wb_ch_r  <= cmd.ch;
    wb_bus_r <= cmd.bus;
    prod_r   <= mult_full[63:0];
    if (cmd.start) begin
      in_r <= in_data;
      for (int b = 0; b < NBUS; b++) begin
        acc_r[b][0] <= '0;
        acc_r[b][1] <= '0;
      end
    end
    if (acc_en) begin
      acc_r[acc_b][acc_s] <= acc_r[acc_b][acc_s] + prod_r[47:0];
    end
    unique case (wb_op_r)
      scmix_pkg::OP_LM: begin
        lm_r <= prod_r[14:0];
        dl_r <= 33'(xs_wl) - 33'(lpl_r[wb_ch_r]);
        dr_r <= 33'(xs_wr) - 33'(lpr_r[wb_ch_r]);
        yl_r <= 28'(x_wl);
        yr_r <= 28'(x_wr);
      end
      scmix_pkg::OP_TLO: lo_r <= prod_r[43:29];
      scmix_pkg::OP_THI: begin
        hi_r   <= prod_r[43:29];
        diff_r <= $signed({2'b00, lo_r}) - $signed({2'b00, prod_r[43:29]});
      end
      scmix_pkg::OP_GL1: tl_r   <= prod_r[29:0] + 30'd5000;
      scmix_pkg::OP_GR1: tr_r   <= prod_r[29:0] + 30'd5000;
      scmix_pkg::OP_GL2: gl_r   <= prod_r[59:44];
      scmix_pkg::OP_GR2: gr_r   <= prod_r[59:44];
      scmix_pkg::OP_FL1: nlpl_r <= nlp_w;
      scmix_pkg::OP_FR1: nlpr_r <= nlp_w;
      scmix_pkg::OP_FL2: pl_r   <= prod_r[49:0];
      scmix_pkg::OP_FR2: pr_r   <= prod_r[49:0];
      scmix_pkg::OP_FL3: yl_r   <= y_w[27:0];
      scmix_pkg::OP_FR3: yr_r   <= y_w[27:0];
      scmix_pkg::OP_A1L: sgl_r  <= prod_r[21:0] + 22'd50;
      scmix_pkg::OP_A1R: sgr_r  <= prod_r[21:0] + 22'd50;
      scmix_pkg::OP_A2L: agl_r  <= prod_r[44:29];
      scmix_pkg::OP_A2R: agr_r  <= prod_r[44:29];
      default: ;
    endcase
    if (cmd.fin) begin
      out_r.main_left  <= round_sat(acc_r[0][0]);
      out_r.main_right <= round_sat(acc_r[0][1]);
      out_r.aux1_left  <= round_sat(acc_r[1][0]);
      out_r.aux1_right <= round_sat(acc_r[1][1]);
      out_r.aux2_left  <= round_sat(acc_r[2][0]);
      out_r.aux2_right <= round_sat(acc_r[2][1]);
      out_r.aux3_left  <= round_sat(acc_r[3][0]);
      out_r.aux3_right <= round_sat(acc_r[3][1]);
      out_r.aux4_left  <= round_sat(acc_r[4][0]);
      out_r.aux4_right <= round_sat(acc_r[4][1]);
      out_r.aux5_left  <= round_sat(acc_r[5][0]);
      out_r.aux5_right <= round_sat(acc_r[5][1]);
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/stereo_channel_mixer_with_sends_core.sv */
// ----------------------------------------------------------------------------
// stereo_channel_mixer_with_sends_core
// Six-channel stereo mixer with tilt EQ, constant-power pan, main bus and
// aux send buses.
// ----------------------------------------------------------------------------
// One frame is mixed at a time on a single shared 34x32 multiplier, one
// operation per cycle. For every channel that is not muted or soloed out
// it works out the gains and the main bus, runs the tilt filter when the
// tilt is not flat and then feeds each aux bus in turn. The next frame can
// be taken in the cycle after the result is registered. The result waits
// in an output register, so a stalled output does not hold up the next
// frame until its own result is ready.
// Configuration writes are always accepted and should be made while idle.
module stereo_channel_mixer_with_sends_core #(
  parameter int CHANNEL_COUNT = scmix_pkg::CHANNEL_COUNT_DEF,
  parameter int AUX_BUS_COUNT = scmix_pkg::AUX_BUS_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scmix_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output scmix_pkg::out_t                  out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scmix_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scmix_pkg::SET_W-1:0]      cfg_data
);

  scmix_pkg::cmd_t  cmd;
  scmix_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  scmix_ctrl #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .AUX_BUS_COUNT(AUX_BUS_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scmix_dp #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

/* rtl/core/scmix_chk.sv */
// ----------------------------------------------------------------------------
// scmix_chk
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module scmix_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input scmix_pkg::out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word changed while stalled");

  // one frame in flight: no new word right after one is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a frame is in progress");

  // a result never shows up on the cycle after a frame is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind stereo_channel_mixer_with_sends_core scmix_chk u_scmix_chk (.*);

/* verif/scmix_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scmix_checker
// Watches the frame, result and register channels of the stereo mixer. It
// keeps its own copy of the register file and tilt filter state, works out
// the bus sums of every accepted frame and compares each returned word, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module scmix_checker
  import scmix_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]     cfg_data,
  output int                   err_count,
  output int                   pending
);

  localparam int  FIELDS = 2 * NBUS;
  localparam int  LP_SH  = 32 - SAMPLE_W;
  localparam longint SMAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  logic [SET_W-1:0] chan_set [NCH];
  logic [7:0]       master_lvl;
  logic [15:0]      lp_coef;
  int               lp_left  [NCH];
  int               lp_right [NCH];
  longint           pan_gain [201];
  out_t             mix_q[$];

  // Q2.14 pan curve from a Taylor series in Q30
  function automatic longint pan_point(int k);
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned t;
    longint unsigned div;
    longint          acc;
    bit              sine;
    sine = (k > 100);
    ang  = longint'(sine ? 200 - k : k) * PI_Q30 / 400;
    sq   = (ang * ang) >> 30;
    t    = sine ? ang : (64'd1 << 30);
    acc  = longint'(t);
    for (int n = 1; n <= 8; n++) begin
      div = sine ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
      t = ((t * sq) >> 30) / div;
      acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
    end
    return (acc + 32768) >>> 16;
  endfunction

  initial begin
    for (int k = 0; k <= 200; k++) pan_gain[k] = pan_point(k);
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint hi);
    return v > hi ? hi : v;
  endfunction

  // one-pole split into low and high parts, advancing the channel's state
  function automatic longint tilt_eq(int c, bit right, longint x, longint lo, longint hi);
    longint xs;
    longint lp;
    longint nlp;
    xs  = x <<< LP_SH;
    lp  = right ? lp_right[c] : lp_left[c];
    nlp = lp + round_shift(longint'(lp_coef) * (xs - lp), 16);
    if (right) lp_right[c] = int'(nlp);
    else lp_left[c] = int'(nlp);
    return round_shift(nlp * lo + (xs - nlp) * hi, LP_SH + 14);
  endfunction

  function automatic out_t mix_frame(in_t f);
    longint acc [FIELDS];
    logic [FIELDS*SAMPLE_W-1:0] flat_in;
    logic [FIELDS*SAMPLE_W-1:0] flat_out;
    bit     soloed;
    longint lvl, pan, tlt, mst, snd, yl, yr, gl, gr, lo, hi, v;
    flat_in = f;
    mst = clip(master_lvl, 150);
    soloed = 0;
    for (int b = 0; b < FIELDS; b++) acc[b] = 0;
    for (int c = 0; c < NCH; c++) soloed |= chan_set[c][SOLO_BIT];
    for (int c = 0; c < NCH; c++) begin
      if (chan_set[c][MUTE_BIT] || (soloed && !chan_set[c][SOLO_BIT])) continue;
      lvl = clip(chan_set[c][7:0], 150);
      pan = clip(chan_set[c][15:8], 200);
      tlt = clip(chan_set[c][23:16], 200);
      yl = longint'($signed(flat_in[FIELDS*SAMPLE_W-1-2*c*SAMPLE_W -: SAMPLE_W]));
      yr = longint'($signed(flat_in[FIELDS*SAMPLE_W-1-(2*c+1)*SAMPLE_W -: SAMPLE_W]));
      gl = (lvl * mst * pan_gain[pan] + 5000) / 10000;
      gr = (lvl * mst * pan_gain[200 - pan] + 5000) / 10000;
      if (tlt != 100) begin
        lo = (16384 * (300 - tlt) + 100) / 200;
        hi = (16384 * (100 + tlt) + 100) / 200;
        yl = tilt_eq(c, 1'b0, yl, lo, hi);
        yr = tilt_eq(c, 1'b1, yr, lo, hi);
      end
      acc[0] += yl * gl;
      acc[1] += yr * gr;
      for (int b = 1; b < NBUS; b++) begin
        snd = clip(chan_set[c][SEND_LSB + SEND_W*(b-1) +: SEND_W], 100);
        if (snd == 0) continue;
        acc[2*b]   += yl * ((gl * snd + 50) / 100);
        acc[2*b+1] += yr * ((gr * snd + 50) / 100);
      end
    end
    for (int k = 0; k < FIELDS; k++) begin
      v = round_shift(acc[k], 14);
      if (v > SMAX) v = SMAX;
      if (v < SMIN) v = SMIN;
      flat_out[FIELDS*SAMPLE_W-1-k*SAMPLE_W -: SAMPLE_W] = v[SAMPLE_W-1:0];
    end
    return out_t'(flat_out);
  endfunction

  assign pending = mix_q.size();

  always @(posedge clk) begin
    out_t want;
    logic [FIELDS*SAMPLE_W-1:0] w;
    logic [FIELDS*SAMPLE_W-1:0] got;
    bit bad;
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        chan_set[c] = SET_RESET;
        lp_left[c]  = 0;
        lp_right[c] = 0;
      end
      master_lvl = MASTER_RESET;
      lp_coef    = COEF_RESET;
      err_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MASTER) master_lvl = cfg_data[7:0];
        else if (cfg_index == REG_COEF) lp_coef = cfg_data[15:0];
        else chan_set[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) mix_q = {mix_q, mix_frame(in_data)};
      if (out_valid && out_ready) begin
        if (mix_q.size() == 0) begin
          if (err_count < 10) $display("unexpected result word %h", out_data);
          err_count <= err_count + 1;
        end else begin
          want = mix_q.pop_front();
          w = want;
          got = out_data;
          bad = 0;
          for (int k = 0; k < FIELDS; k++) begin
            if (w[FIELDS*SAMPLE_W-1-k*SAMPLE_W -: SAMPLE_W] !==
                got[FIELDS*SAMPLE_W-1-k*SAMPLE_W -: SAMPLE_W]) begin
              if (err_count < 10 && !bad)
                $display("bus %0d %s: expected %0d got %0d", k / 2, (k % 2) ? "right" : "left",
                  $signed(w[FIELDS*SAMPLE_W-1-k*SAMPLE_W -: SAMPLE_W]),
                  $signed(got[FIELDS*SAMPLE_W-1-k*SAMPLE_W -: SAMPLE_W]));
              bad = 1;
            end
          end
          if (bad) err_count <= err_count + 1;
        end
      end
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stereo mixer: directed extreme frames and register
// settings, then phases of random frames under random settings, with random
// gaps on the frame channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb;
  import scmix_pkg::*;

  localparam int LIMIT = 4000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SET_W-1:0]     cfg_data = '0;
  int                   err_count;
  int                   pending;
  int                   cycles = 0;
  int                   stall_left = 0;
  bit                   calm = 0;

  always #5 clk = ~clk;

  stereo_channel_mixer_with_sends_core i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  scmix_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .err_count, .pending
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= idle_len();
      out_ready <= 1'b1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return '0;
      3: return SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic in_t pick_frame();
    logic [2*NCH*SAMPLE_W-1:0] f;
    for (int k = 0; k < 2 * NCH; k++) f[k*SAMPLE_W +: SAMPLE_W] = pick_sample();
    return in_t'(f);
  endfunction

  function automatic logic [SET_W-1:0] pick_settings(bit solo_ok);
    logic [SET_W-1:0] s;
    s = SET_W'({$urandom, $urandom});
    s[7:0]  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 150));
    s[15:8] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 200));
    case ($urandom_range(0, 5))
      0, 1: s[23:16] = 8'd100;
      2: s[23:16] = 8'($urandom);
      default: s[23:16] = 8'($urandom_range(0, 200));
    endcase
    s[MUTE_BIT] = ($urandom_range(0, 7) == 0);
    s[SOLO_BIT] = solo_ok && ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SET_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(in_t f);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= f;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the frames until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all(logic [SET_W-1:0] chs [NCH], logic [7:0] mst, logic [15:0] cf);
    for (int c = 0; c < NCH; c++) write_reg(CFG_IDX_W'(c), chs[c]);
    write_reg(REG_MASTER, SET_W'(mst));
    write_reg(REG_COEF, SET_W'(cf));
  endtask

  initial begin
    logic [SET_W-1:0] chs [NCH];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings with extreme frames, then random ones
    send_frame(in_t'({(2*NCH){1'b0, {(SAMPLE_W-1){1'b1}}}}));
    send_frame(in_t'({(2*NCH){1'b1, {(SAMPLE_W-1){1'b0}}}}));
    send_frame('0);
    send_frame(in_t'({NCH{1'b0, {(SAMPLE_W-1){1'b1}}, 1'b1, {(SAMPLE_W-1){1'b0}}}}));
    for (int i = 0; i < 4; i++) send_frame(pick_frame());
    drain();

    // register fields at top, at clamp limit, at zero, then full level only
    for (int c = 0; c < NCH; c++) chs[c] = '1;
    set_all(chs, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_frame(in_t'({(2*NCH){1'b0, {(SAMPLE_W-1){1'b1}}}}));
    drain();
    for (int c = 0; c < NCH; c++) chs[c] = {{(SET_W-24){1'b1}}, 8'd200, 8'd200, 8'd150};
    set_all(chs, 8'd150, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_frame(pick_frame());
    drain();
    for (int c = 0; c < NCH; c++) chs[c] = '0;
    set_all(chs, 8'd0, 16'd0);
    for (int i = 0; i < 3; i++) send_frame(pick_frame());
    drain();
    for (int c = 0; c < NCH; c++) chs[c] = {{(SET_W-24){1'b0}}, 8'd0, 8'd0, 8'd150};
    set_all(chs, 8'd150, 16'd0);
    for (int i = 0; i < 4; i++) send_frame(pick_frame());
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      calm = (ph % 5 == 2);
      for (int c = 0; c < NCH; c++) chs[c] = pick_settings(ph % 3 == 1);
      set_all(chs,
        ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 150)),
        ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0)
                                    : 16'($urandom));
      for (int i = 0; i < 100; i++) send_frame(pick_frame());
      drain();
    end

    repeat (300) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/scmix_pkg.sv
rtl/core/scmix_ctrl.sv
rtl/core/scmix_dp.sv
rtl/core/stereo_channel_mixer_with_sends_core.sv
rtl/core/scmix_chk.sv
verif/scmix_checker.sv
verif/tb.sv
